// ----- src/vertex_neighbor_smoothing_defines.svh -----
// Assertion macros for the vertex neighbor smoothing checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef VERTEX_NEIGHBOR_SMOOTHING_DEFINES_SVH
`define VERTEX_NEIGHBOR_SMOOTHING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VNS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define VNS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/vns_pkg.sv -----
// Shared types, constants and helpers for the vertex neighbor smoothing block.
// No dependencies; used by every other .sv file in src.
`default_nettype none

package vns_pkg;

	localparam int COORD_W       = 32;
	localparam int MAX_NEIGHBORS = 32;
	localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
	localparam int DEN_W         = $clog2(MAX_NEIGHBORS + 2);
	localparam int SUM_W         = COORD_W + $clog2(MAX_NEIGHBORS);
	localparam int NUM_W         = SUM_W + 1;
	localparam int GAIN_W        = 16;
	localparam int GAIN_FRAC     = 12;
	localparam int MULA_W        = NUM_W + 2;
	localparam int PROD_W        = MULA_W + GAIN_W;
	localparam int ACC_W         = PROD_W - GAIN_FRAC;
	localparam int MODE_W        = 2;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int NUM_AXES      = 3;
	localparam int AXIS_W        = $clog2(NUM_AXES);

	localparam logic signed [GAIN_W-1:0] SHRINK_RESET = 16'sd2048;
	localparam logic signed [GAIN_W-1:0] EXPAND_RESET = -16'sd2171;

	// Round half away from zero when dropping the gain fraction bits.
	localparam logic signed [PROD_W-1:0] RND_BIAS_POS = PROD_W'(1 << (GAIN_FRAC - 1));
	localparam logic signed [PROD_W-1:0] RND_BIAS_NEG = PROD_W'((1 << (GAIN_FRAC - 1)) - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_SHRINK = 2'd1,
		REG_EXPAND = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_SIMPLE  = 2'd0,
		MODE_LAPLACE = 2'd1,
		MODE_TAUBIN  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NO_NBR   = 2'd1,
		STAT_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic                      is_own;
		logic                      last_in_group;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [COORD_W-1:0] new_z;
		status_t                   status;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
		logic [ACC_W-COORD_W:0] top;
		top = v[ACC_W-1:COORD_W-1];
		if ((&top) || !(|top))
			return v[COORD_W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(COORD_W-1){1'b0}}};
		else
			return {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

// ----- src/vns_div.sv -----
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on vns_pkg for widths and the request/response structs.
`default_nettype none

module vns_div import vns_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [ITER_W-1:0] iter_q;
	logic              busy_q;
	logic              done_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_diff;
	logic           fits;

	always_comb begin
		trial      = {rem_q, quo_q[NUM_W-1]};
		trial_diff = trial - {1'b0, den_q};
		fits       = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= ITER_W'(NUM_W);
		end else if (busy_q) begin
			iter_q <= iter_q - ITER_W'(1);
			if (iter_q == ITER_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			// shift in the next dividend bit, subtract when the divisor fits
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

`default_nettype wire

// ----- src/vertex_neighbor_smoothing.sv -----
// Vertex neighbor smoothing: accumulates a vertex group and emits one smoothed position.
// Depends on vns_pkg and instantiates the serial divider vns_div.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item): send the vertex's own position with
//   is_own set, then its neighbors; mark the final item with last_in_group. Each item
//   that is not marked last is taken at once and in_stall stays low.
//   After a last item transfers, in_stall stays high while the result is computed.
//   The three axes run one after another through one shared 38-step serial divider
//   and one gain multiplier; simple mode skips the gain steps, laplacian mode applies
//   shrink once, taubin mode shrink then expand; a group with no neighbors skips both.
//   Output channel (out_valid / out_stall / out_item): one result per group, held in
//   an output register until it transfers. Further groups may stream in meanwhile;
//   the next result waits in the block until the output register frees up.
//   Configuration (cfg_wr_en / cfg_index / cfg_data) is to be written between groups; the block does not enforce it.
//   Reset restores mode laplacian, shrink 0.5, expand -0.53, clears the own position,
//   the sums and the count, and empties the output register.
`default_nettype none

module vertex_neighbor_smoothing import vns_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_item_t             in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_item_t                 out_item,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_CHECK  = 11'b000_0000_0010,
		ST_PREP   = 11'b000_0000_0100,
		ST_DSTART = 11'b000_0000_1000,
		ST_DWAIT  = 11'b000_0001_0000,
		ST_DIFF   = 11'b000_0010_0000,
		ST_MUL    = 11'b000_0100_0000,
		ST_RND    = 11'b000_1000_0000,
		ST_ACC    = 11'b001_0000_0000,
		ST_SAT    = 11'b010_0000_0000,
		ST_PUSH   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic [MODE_W-1:0]        mode_q;
	logic signed [GAIN_W-1:0] shrink_q;
	logic signed [GAIN_W-1:0] expand_q;

	logic signed [COORD_W-1:0] own_q [NUM_AXES];
	logic signed [SUM_W-1:0]   sum_q [NUM_AXES];
	logic [CNT_W-1:0]          cnt_q;
	logic                      ovf_q;

	logic [AXIS_W-1:0]         axis_q;
	logic                      phase_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]          den_q;
	logic signed [NUM_W-1:0]   mean_q;
	logic signed [ACC_W-1:0]   base_q;
	logic signed [MULA_W-1:0]  mula_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   rnd_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [COORD_W-1:0] res_q [NUM_AXES];
	status_t                   st_q;

	out_item_t out_q;
	logic      out_valid_q;

	logic signed [COORD_W-1:0] in_pos [NUM_AXES];
	logic                      in_xfer;
	logic                      out_xfer;
	logic                      push_ok;
	logic                      is_simple;
	logic                      is_taubin;
	logic signed [NUM_W-1:0]   quo_signed;
	logic signed [GAIN_W-1:0]  gain_sel;
	logic signed [PROD_W-1:0]  rnd_sum;
	logic signed [ACC_W-1:0]   acc_sum;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign in_pos[0] = in_item.pos_x;
	assign in_pos[1] = in_item.pos_y;
	assign in_pos[2] = in_item.pos_z;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign push_ok   = !out_valid_q || !out_stall;
	assign is_simple = (mode_q == MODE_SIMPLE);
	// mode 3 acts as taubin
	assign is_taubin = mode_q[1];

	always_comb begin
		div_req.start = (state_q == ST_DSTART);
		// magnitude plus half the divisor: ~n + 1 + h for negative numerators
		div_req.num   = (num_q[NUM_W-1] ? ~$unsigned(num_q) : $unsigned(num_q))
			+ NUM_W'(den_q >> 1) + NUM_W'(num_q[NUM_W-1]);
		div_req.den   = den_q;
		quo_signed    = num_q[NUM_W-1] ? -$signed(div_rsp.quo) : $signed(div_rsp.quo);
		gain_sel      = phase_q ? expand_q : shrink_q;
		rnd_sum       = prod_q + (prod_q[PROD_W-1] ? RND_BIAS_NEG : RND_BIAS_POS);
		acc_sum       = base_q + rnd_q;
	end

	vns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LAPLACE;
			shrink_q <= SHRINK_RESET;
			expand_q <= EXPAND_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				REG_SHRINK: shrink_q <= cfg_data[GAIN_W-1:0];
				REG_EXPAND: expand_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// group accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				own_q[i] <= '0;
				sum_q[i] <= '0;
			end
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_xfer) begin
			if (in_item.is_own) begin
				for (int i = 0; i < NUM_AXES; i++) begin
					own_q[i] <= in_pos[i];
					sum_q[i] <= '0;
				end
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (cnt_q < CNT_W'(MAX_NEIGHBORS)) begin
				for (int i = 0; i < NUM_AXES; i++)
					sum_q[i] <= sum_q[i] + SUM_W'(in_pos[i]);
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (state_q == ST_PUSH && push_ok) begin
			for (int i = 0; i < NUM_AXES; i++)
				sum_q[i] <= '0;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && in_item.last_in_group)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					axis_q  <= '0;
					state_q <= (cnt_q == '0) ? ST_PUSH : ST_PREP;
				end
				ST_PREP:   state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (div_rsp.done) begin
						phase_q <= 1'b0;
						state_q <= is_simple ? ST_SAT : ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_RND;
				ST_RND:  state_q <= ST_ACC;
				ST_ACC: begin
					if (is_taubin && !phase_q) begin
						phase_q <= 1'b1;
						state_q <= ST_DIFF;
					end else begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (axis_q == AXIS_W'(NUM_AXES - 1)) begin
						state_q <= ST_PUSH;
					end else begin
						axis_q  <= axis_q + AXIS_W'(1);
						state_q <= ST_PREP;
					end
				end
				ST_PUSH: begin
					if (push_ok)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_CHECK: begin
				if (cnt_q == '0) begin
					for (int i = 0; i < NUM_AXES; i++)
						res_q[i] <= own_q[i];
					st_q <= STAT_NO_NBR;
				end else begin
					st_q <= ovf_q ? STAT_OVERFLOW : STAT_OK;
				end
			end
			ST_PREP: begin
				if (is_simple) begin
					num_q <= NUM_W'(own_q[axis_q]) + NUM_W'(sum_q[axis_q]);
					den_q <= DEN_W'(cnt_q) + DEN_W'(1);
				end else begin
					num_q <= NUM_W'(sum_q[axis_q]);
					den_q <= DEN_W'(cnt_q);
				end
			end
			ST_DWAIT: begin
				if (div_rsp.done) begin
					mean_q <= quo_signed;
					acc_q  <= ACC_W'(quo_signed);
					base_q <= ACC_W'(own_q[axis_q]);
				end
			end
			ST_DIFF: mula_q <= MULA_W'(mean_q) - MULA_W'(base_q);
			ST_MUL:  prod_q <= mula_q * gain_sel;
			ST_RND:  rnd_q  <= ACC_W'(rnd_sum >>> GAIN_FRAC);
			ST_ACC: begin
				// the shrunk point stays far inside the 44-bit intermediate limit here
				acc_q  <= acc_sum;
				base_q <= acc_sum;
			end
			ST_SAT: res_q[axis_q] <= sat_coord(acc_q);
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && push_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && push_ok) begin
			out_q.new_x  <= res_q[0];
			out_q.new_y  <= res_q[1];
			out_q.new_z  <= res_q[2];
			out_q.status <= st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

// ----- src/vns_checker.sv -----
// Port-level checker for vertex_neighbor_smoothing, attached by bind below.
// Depends on vns_pkg and the assertion macros in vertex_neighbor_smoothing_defines.svh.
`default_nettype none
`include "vertex_neighbor_smoothing_defines.svh"

module vns_props import vns_pkg::*; (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_stall,
	input wire in_item_t             in_item,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire out_item_t            out_item
);

	logic in_xfer;

	assign in_xfer = in_valid && !in_stall;

	// a stalled result holds
	`VNS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")
	// a neighbor that does not close the group leaves the input open
	`VNS_ASSERT_NEXT(a_nbr_open, in_xfer && !in_item.last_in_group, !in_stall, "input closed after a neighbor")
	// closing a group stalls the input for the computation that follows
	`VNS_ASSERT_NEXT(a_last_busy, in_xfer && in_item.last_in_group, in_stall ##1 in_stall, "input reopened too early after group end")
	// a new result is only loaded from the compute side
	`VNS_ASSERT_NOW(a_load_src, $rose(out_valid), $past(in_stall), "result appeared without a computation")

endmodule

bind vertex_neighbor_smoothing vns_props u_vns_props (.*);

`default_nettype wire
